// ===== hdl/imubss_pkg.sv =====
`default_nettype none

package imubss_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_START    = 2'd0;
  localparam logic [1:0] REQ_COMPLETE = 2'd1;
  localparam logic [1:0] REQ_ERROR    = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  // Phase codes, also reported as state_code.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ACC  = 2'd1;
  localparam logic [1:0] PH_GYRO = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  // Burst targets reported as launch_target.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ACC  = 2'd1;
  localparam logic [1:0] TGT_GYRO = 2'd2;

  // Configuration register indexes (byte address 4 * index).
  localparam logic [1:0] REG_ACC_CMD  = 2'd0;
  localparam logic [1:0] REG_GYRO_CMD = 2'd1;
  localparam logic [1:0] REG_MAX_DT   = 2'd2;

  localparam int ADDR_WIDTH = 4;

  localparam logic [7:0]  ACC_CMD_RESET  = 8'h92;
  localparam logic [7:0]  GYRO_CMD_RESET = 8'h82;
  localparam logic [15:0] MAX_DT_RESET   = 16'd100;

  typedef struct packed {
    logic [7:0]  acc_cmd;
    logic [7:0]  gyro_cmd;
    logic [15:0] max_dt;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  state_code;
    logic [1:0]  launch_target;
    logic [7:0]  launch_byte;
    logic        start_refused;
    logic        sample_valid;
    logic [47:0] acc_axes;
    logic [47:0] gyro_axes;
    logic [15:0] dt_ticks;
    logic [31:0] error_total;
    logic [31:0] skip_total;
    logic [31:0] sample_total;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/imu_burst_sample_sequencer.sv =====
`default_nettype none

// IMU burst sample sequencer.
//
// Each request on the input channel (in_valid / in_stall) carries a start tick, a
// transfer completion, a transfer error or a consumer read, together with the burst
// payload and the serial engine's launch acknowledge. Every accepted request yields
// exactly one result on the output channel (out_valid / out_stall): the new phase,
// the burst launched, counters and, on a consumer read, the unpacked sample.
//
// The request is decoded against the current sequencer state by one level of
// compare and increment logic and lands in the output register at the accepting
// edge. Throughput is one request per cycle while not stalled. in_stall is high
// only while a result sits in the output register and the receiver stalls it;
// the result then holds until taken, and the following request waits at the input.
//
// Synchronous reset returns the phase to idle, empties the snapshot slot, clears
// the counters and sequence marks, empties the output register and loads the
// configuration defaults (0x92, 0x82, 100). The APB port is always ready and
// should be written only while no request is in flight.
module imu_burst_sample_sequencer #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [imubss_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        req_type,
  input  wire logic [47:0]                       rx_payload,
  input  wire logic                              launch_ok,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [1:0]                        state_code,
  output logic      [1:0]                        launch_target,
  output logic      [7:0]                        launch_byte,
  output logic                                   start_refused,
  output logic                                   sample_valid,
  output logic      [47:0]                       acc_axes,
  output logic      [47:0]                       gyro_axes,
  output logic      [15:0]                       dt_ticks,
  output logic      [31:0]                       error_total,
  output logic      [31:0]                       skip_total,
  output logic      [31:0]                       sample_total
);
  import imubss_pkg::*;

  cfg_t    cfg;
  result_t res_next;
  result_t res;
  logic    step;

  // A request is taken whenever the output register can receive its result.
  assign step = in_valid && !in_stall;

  imubss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imubss_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req_type   (req_type),
    .rx_payload (rx_payload),
    .launch_ok  (launch_ok),
    .cfg        (cfg),
    .res        (res_next)
  );

  imubss_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (in_stall),
    .res_out   (res)
  );

  // Chip selects follow the phase: the accelerometer is selected in PH_ACC and the
  // gyroscope in PH_GYRO, so state_code alone drives them outside this block.
  assign state_code    = res.state_code;
  assign launch_target = res.launch_target;
  assign launch_byte   = res.launch_byte;
  assign start_refused = res.start_refused;
  assign sample_valid  = res.sample_valid;
  assign acc_axes      = res.acc_axes;
  assign gyro_axes     = res.gyro_axes;
  assign dt_ticks      = res.dt_ticks;
  assign error_total   = res.error_total;
  assign skip_total    = res.skip_total;
  assign sample_total  = res.sample_total;

  // The input is held back only while a result waits in the output register.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A launched burst always matches the phase that it puts the sequencer in.
  a_launch_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && launch_target != TGT_NONE |->
      (launch_target == TGT_ACC && state_code == PH_ACC) ||
      (launch_target == TGT_GYRO && state_code == PH_GYRO))
    else $error("launch target disagrees with phase");

  // A refused start leaves the sequencer in a reading phase.
  a_refused_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_refused |-> state_code == PH_ACC || state_code == PH_GYRO)
    else $error("refused start outside a read");

  // A delivered sample never comes with a launch or a refusal.
  a_sample_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> launch_target == TGT_NONE && !start_refused)
    else $error("sample delivered with launch or refusal");

endmodule

`default_nettype wire

// ===== hdl/imubss_cfg.sv =====
`default_nettype none

module imubss_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [imubss_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output imubss_pkg::cfg_t                      cfg
);
  import imubss_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.acc_cmd  <= ACC_CMD_RESET;
      cfg.gyro_cmd <= GYRO_CMD_RESET;
      cfg.max_dt   <= MAX_DT_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_ACC_CMD:  cfg.acc_cmd  <= pwdata[7:0];
        REG_GYRO_CMD: cfg.gyro_cmd <= pwdata[7:0];
        REG_MAX_DT:   cfg.max_dt   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ACC_CMD:  prdata = {24'd0, cfg.acc_cmd};
      REG_GYRO_CMD: prdata = {24'd0, cfg.gyro_cmd};
      REG_MAX_DT:   prdata = {16'd0, cfg.max_dt};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/imubss_core.sv =====
`default_nettype none

module imubss_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [1:0]          req_type,
  input  wire logic [47:0]         rx_payload,
  input  wire logic                launch_ok,
  input  wire imubss_pkg::cfg_t    cfg,
  output imubss_pkg::result_t      res
);
  import imubss_pkg::*;

  logic [1:0]             phase, phase_next;
  logic [47:0]            acc_latch, acc_latch_next;
  logic [47:0]            snap_acc;
  logic [47:0]            snap_gyro;
  logic                   snap_load;
  logic [COUNT_WIDTH-1:0] snap_sequence, snap_sequence_next;
  logic                   slot_ready, slot_ready_next;
  logic [COUNT_WIDTH-1:0] last_sequence, last_sequence_next;
  logic [COUNT_WIDTH-1:0] error_counter, error_counter_next;
  logic [COUNT_WIDTH-1:0] skip_counter, skip_counter_next;
  logic [COUNT_WIDTH-1:0] sample_counter, sample_counter_next;
  logic [COUNT_WIDTH-1:0] delta;
  logic [31:0]            dt_raw;

  assign delta = snap_sequence - last_sequence;

  always_comb begin
    phase_next          = phase;
    acc_latch_next      = acc_latch;
    snap_load           = 1'b0;
    snap_sequence_next  = snap_sequence;
    slot_ready_next     = slot_ready;
    last_sequence_next  = last_sequence;
    error_counter_next  = error_counter;
    skip_counter_next   = skip_counter;
    sample_counter_next = sample_counter;
    dt_raw              = 32'd0;

    res.launch_target = TGT_NONE;
    res.launch_byte   = 8'd0;
    res.start_refused = 1'b0;
    res.sample_valid  = 1'b0;
    res.acc_axes      = 48'd0;
    res.gyro_axes     = 48'd0;
    res.dt_ticks      = 16'd0;

    case (req_type)
      REQ_START: begin
        if (phase == PH_ACC || phase == PH_GYRO) begin
          res.start_refused = 1'b1;
          skip_counter_next = skip_counter + 1'b1;
        end else if (launch_ok) begin
          phase_next        = PH_ACC;
          res.launch_target = TGT_ACC;
          res.launch_byte   = cfg.acc_cmd;
        end else begin
          phase_next         = PH_ERR;
          error_counter_next = error_counter + 1'b1;
        end
      end
      REQ_COMPLETE: begin
        if (phase == PH_ACC) begin
          acc_latch_next = rx_payload;
          if (launch_ok) begin
            phase_next        = PH_GYRO;
            res.launch_target = TGT_GYRO;
            res.launch_byte   = cfg.gyro_cmd;
          end else begin
            phase_next         = PH_ERR;
            error_counter_next = error_counter + 1'b1;
          end
        end else if (phase == PH_GYRO) begin
          sample_counter_next = sample_counter + 1'b1;
          phase_next          = PH_IDLE;
          if (!slot_ready) begin
            snap_load          = 1'b1;
            snap_sequence_next = sample_counter_next;
            slot_ready_next    = 1'b1;
          end else begin
            skip_counter_next = skip_counter + 1'b1;
          end
        end else begin
          phase_next         = PH_ERR;
          error_counter_next = error_counter + 1'b1;
        end
      end
      REQ_ERROR: begin
        phase_next         = PH_ERR;
        error_counter_next = error_counter + 1'b1;
      end
      default: begin
        if (slot_ready) begin
          res.sample_valid   = 1'b1;
          res.acc_axes       = snap_acc;
          res.gyro_axes      = snap_gyro;
          slot_ready_next    = 1'b0;
          last_sequence_next = snap_sequence;
          // The first read after reset, or a repeat of the same sequence, counts one tick.
          if (last_sequence == '0 || delta == '0) begin
            dt_raw = 32'd1;
          end else begin
            dt_raw = 32'(delta);
          end
          if (dt_raw > 32'(cfg.max_dt)) begin
            res.dt_ticks = cfg.max_dt;
          end else begin
            res.dt_ticks = dt_raw[15:0];
          end
        end
      end
    endcase

    res.state_code   = phase_next;
    res.error_total  = 32'(error_counter_next);
    res.skip_total   = 32'(skip_counter_next);
    res.sample_total = 32'(sample_counter_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      acc_latch      <= 48'd0;
      snap_sequence  <= '0;
      slot_ready     <= 1'b0;
      last_sequence  <= '0;
      error_counter  <= '0;
      skip_counter   <= '0;
      sample_counter <= '0;
    end else if (step) begin
      phase          <= phase_next;
      acc_latch      <= acc_latch_next;
      snap_sequence  <= snap_sequence_next;
      slot_ready     <= slot_ready_next;
      last_sequence  <= last_sequence_next;
      error_counter  <= error_counter_next;
      skip_counter   <= skip_counter_next;
      sample_counter <= sample_counter_next;
    end
  end

  // The snapshot holds no reset value; it is read only after slot_ready was set.
  always_ff @(posedge clk) begin
    if (step && snap_load) begin
      snap_acc  <= acc_latch;
      snap_gyro <= rx_payload;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imubss_out.sv =====
`default_nettype none

module imubss_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire imubss_pkg::result_t res_in,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic                     busy,
  output imubss_pkg::result_t      res_out
);
  import imubss_pkg::*;

  // The register can take a new result whenever it is empty or being emptied.
  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire
